>>> src/tpct_pkg.sv
package tpct_pkg;

  // Converter code that marks a reading as unusable
  localparam logic [7:0] FULL_SCALE = 8'd255;

  // Configuration register indexes
  localparam logic [2:0] CFG_WIDTH_PIXELS  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT_PIXELS = 3'd1;
  localparam logic [2:0] CFG_MIN_X         = 3'd2;
  localparam logic [2:0] CFG_MAX_X         = 3'd3;
  localparam logic [2:0] CFG_MIN_Y         = 3'd4;
  localparam logic [2:0] CFG_MAX_Y         = 3'd5;
  localparam logic [2:0] CFG_FLIP          = 3'd6;

  // Scaling unit operand widths
  localparam int unsigned MulAW  = 8;
  localparam int unsigned MulBW  = 12;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned PixW   = 16;

  // Top level sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_X_GO,
    ST_X_WAIT,
    ST_Y_GO,
    ST_Y_WAIT,
    ST_DONE
  } tp_state_e;

  // Multiply / divide unit sequencer
  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_state_e;

  // Request into the scaling unit: q = (a * b) / d
  typedef struct packed {
    logic               start;
    logic [MulAW-1:0]   a;
    logic [MulBW-1:0]   b;
    logic [MulAW-1:0]   d;
  } md_req_t;

  // Result out of the scaling unit, saturated to 16 bits
  typedef struct packed {
    logic               done;
    logic [PixW-1:0]    quo;
  } md_res_t;

endpackage

>>> src/tpct_muldiv.sv
module tpct_muldiv
  import tpct_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_res_t res_o
);

  md_state_e state_q, state_d;

  logic [ProdW-1:0] acc_q, acc_d;
  logic [ProdW-1:0] bsh_q, bsh_d;
  logic [MulAW-1:0] a_q, a_d;
  logic [MulAW-1:0] d_q, d_d;
  logic [MulAW-1:0] rem_q, rem_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             done_q, done_d;

  // Two restoring division steps per cycle
  logic [MulAW:0]   t1, t2;
  logic             ge1, ge2;
  logic [MulAW-1:0] r1, r2;
  logic [ProdW-1:0] acc1;
  logic             mul_last, div_last;

  assign mul_last = (cnt_q == 4'(MulAW - 1));
  assign div_last = (cnt_q == 4'(ProdW / 2 - 1));

  always_comb begin
    t1   = {rem_q, acc_q[ProdW-1]};
    ge1  = (t1 >= {1'b0, d_q});
    r1   = ge1 ? MulAW'(t1 - {1'b0, d_q}) : t1[MulAW-1:0];
    acc1 = {acc_q[ProdW-2:0], ge1};
    t2   = {r1, acc1[ProdW-1]};
    ge2  = (t2 >= {1'b0, d_q});
    r2   = ge2 ? MulAW'(t2 - {1'b0, d_q}) : t2[MulAW-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      MD_IDLE: if (req_i.start) state_d = MD_MUL;
      MD_MUL:  if (mul_last) state_d = MD_DIV;
      MD_DIV:  if (div_last) state_d = MD_IDLE;
      default: state_d = MD_IDLE;
    endcase
  end

  // Datapath: shift-add multiply one bit a cycle, then divide two bits a cycle
  always_comb begin
    acc_d  = acc_q;
    bsh_d  = bsh_q;
    a_d    = a_q;
    d_d    = d_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    case (state_q)
      MD_IDLE: begin
        if (req_i.start) begin
          acc_d = '0;
          bsh_d = ProdW'(req_i.b);
          a_d   = req_i.a;
          d_d   = req_i.d;
          cnt_d = '0;
        end
      end
      MD_MUL: begin
        if (a_q[0]) acc_d = acc_q + bsh_q;
        bsh_d = {bsh_q[ProdW-2:0], 1'b0};
        a_d   = {1'b0, a_q[MulAW-1:1]};
        cnt_d = mul_last ? '0 : cnt_q + 4'd1;
        rem_d = '0;
      end
      MD_DIV: begin
        acc_d  = {acc1[ProdW-2:0], ge2};
        rem_d  = r2;
        cnt_d  = cnt_q + 4'd1;
        done_d = div_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    bsh_q <= bsh_d;
    a_q   <= a_d;
    d_q   <= d_d;
    rem_q <= rem_d;
  end

  // Quotient holds the full product width; clamp to 16 bits
  assign res_o.done = done_q;
  assign res_o.quo  = (|acc_q[ProdW-1:PixW]) ? {PixW{1'b1}} : acc_q[PixW-1:0];

endmodule

>>> src/touch_panel_calibrate_and_track.sv
// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata 48b, tuser 1b (pen_down)
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata 80b, tuser 3b (flags)
// cfg       in         cfg_valid_i/cfg_ready_o      cfg_index_i 3b, cfg_data_i 12b
//
// One request at a time. A pen-down sample with a usable pair makes, from accept
// to result, two passes through the shared multiply/divide unit, each a multiply
// phase then a divide phase plus hand-off. Other samples go from accept straight to
// the completion state. Reset restores calibration defaults and clears tracking
// state. A waiting result does not block the next accept; a finished result waits
// for m_axis_tready before the following request can complete.
module touch_panel_calibrate_and_track
  import tpct_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // raw_x [7:0], raw_y [15:8], now_ms [47:16]
  input  logic [47:0] s_axis_tdata,
  // pen_down [0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x_reading [7:0], y_reading [15:8], x_pixel [31:16], y_pixel [47:32],
  // held_ms [79:48]
  output logic [79:0] m_axis_tdata,
  // touching [0], landscape [1], reading_ok [2]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);

  tp_state_e state_q, state_d;

  // Calibration registers
  logic [11:0] width_q, height_q;
  logic [7:0]  min_x_q, max_x_q, min_y_q, max_y_q;
  logic        flip_q;

  // Tracking state
  logic [7:0]  last_x_rd_q, last_y_rd_q;
  logic [15:0] last_x_px_q, last_y_px_q;
  logic        press_active_q;
  logic [31:0] press_start_q, last_held_q;

  // Per-request working registers
  logic [7:0]  rot_x_q, rot_y_q;
  logic        down_q, ok_q, zero_x_q;
  logic [15:0] x_px_q;

  // Output register
  logic [79:0] out_data_q;
  logic [2:0]  out_user_q;
  logic        out_valid_q;

  md_req_t md_req;
  md_res_t md_res;

  logic [7:0]  in_rx, in_ry;
  logic        in_pen, accept, landscape, in_ok, do_scale, out_free;
  logic [31:0] in_now;
  logic [7:0]  rot_x, rot_y;
  logic        zero_x, zero_y;

  assign in_rx     = s_axis_tdata[7:0];
  assign in_ry     = s_axis_tdata[15:8];
  assign in_now    = s_axis_tdata[47:16];
  assign in_pen    = s_axis_tuser;
  assign accept    = s_axis_tvalid && s_axis_tready;
  assign landscape = (width_q >= height_q);
  assign in_ok     = (in_rx != FULL_SCALE) && (in_ry != FULL_SCALE);
  assign do_scale  = in_pen && in_ok;
  assign out_free  = !out_valid_q || m_axis_tready;

  // Rotate for portrait, then optional mirror of both axes
  always_comb begin
    rot_x = landscape ? in_rx : in_ry;
    rot_y = landscape ? in_ry : ~in_rx;
    if (flip_q) begin
      rot_x = ~rot_x;
      rot_y = ~rot_y;
    end
  end

  // Reading below min or empty range scales to zero
  assign zero_x = (rot_x < min_x_q) || (max_x_q <= min_x_q);
  assign zero_y = (rot_y < min_y_q) || (max_y_q <= min_y_q);

  logic zero_y_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = do_scale ? ST_X_GO : ST_DONE;
      ST_X_GO:   state_d = ST_X_WAIT;
      ST_X_WAIT: if (md_res.done) state_d = ST_Y_GO;
      ST_Y_GO:   state_d = ST_Y_WAIT;
      ST_Y_WAIT: if (md_res.done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: scaling unit request and input ready
  always_comb begin
    s_axis_tready = 1'b0;
    md_req.start  = 1'b0;
    md_req.a      = rot_x_q - min_x_q;
    md_req.b      = width_q;
    md_req.d      = zero_x_q ? 8'd1 : max_x_q - min_x_q;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_X_GO: md_req.start = 1'b1;
      ST_Y_GO, ST_Y_WAIT: begin
        md_req.start = (state_q == ST_Y_GO);
        md_req.a     = rot_y_q - min_y_q;
        md_req.b     = height_q;
        md_req.d     = zero_y_q ? 8'd1 : max_y_q - min_y_q;
      end
      default: ;
    endcase
  end

  tpct_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .res_o  (md_res)
  );

  assign cfg_ready_o = 1'b1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= '0;
      height_q <= '0;
      min_x_q  <= '0;
      max_x_q  <= FULL_SCALE;
      min_y_q  <= '0;
      max_y_q  <= FULL_SCALE;
      flip_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_WIDTH_PIXELS:  width_q  <= cfg_data_i;
        CFG_HEIGHT_PIXELS: height_q <= cfg_data_i;
        CFG_MIN_X:         min_x_q  <= cfg_data_i[7:0];
        CFG_MAX_X:         max_x_q  <= cfg_data_i[7:0];
        CFG_MIN_Y:         min_y_q  <= cfg_data_i[7:0];
        CFG_MAX_Y:         max_y_q  <= cfg_data_i[7:0];
        CFG_FLIP:          flip_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sequencer, press tracking and stored coordinates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      press_active_q <= 1'b0;
      press_start_q  <= '0;
      last_held_q    <= '0;
      last_x_rd_q    <= '0;
      last_y_rd_q    <= '0;
      last_x_px_q    <= '0;
      last_y_px_q    <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (in_pen) begin
          press_active_q <= 1'b1;
          if (!press_active_q) press_start_q <= in_now;
          else                 last_held_q   <= in_now - press_start_q;
        end else begin
          press_active_q <= 1'b0;
        end
      end
      if (state_q == ST_Y_WAIT && md_res.done) begin
        last_x_rd_q <= rot_x_q;
        last_y_rd_q <= rot_y_q;
        last_x_px_q <= x_px_q;
        last_y_px_q <= zero_y_q ? 16'd0 : md_res.quo;
      end
      if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
      else if (m_axis_tready)             out_valid_q <= 1'b0;
    end
  end

  // Working and output payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rot_x_q  <= rot_x;
      rot_y_q  <= rot_y;
      zero_x_q <= zero_x;
      zero_y_q <= zero_y;
      down_q   <= in_pen;
      ok_q     <= in_ok;
    end
    if (state_q == ST_X_WAIT && md_res.done) begin
      x_px_q <= zero_x_q ? 16'd0 : md_res.quo;
    end
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= {last_held_q, last_y_px_q, last_x_px_q, last_y_rd_q, last_x_rd_q};
      out_user_q <= {ok_q, landscape, down_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  // The scaling unit only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_res.done |-> (state_q == ST_X_WAIT || state_q == ST_Y_WAIT))
    else $error("scaling result outside wait state");

  // A pen-down request always leaves a press open
  a_press_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_axis_tuser) |=> press_active_q)
    else $error("press not opened on pen down");

  // A result only appears from the completion state
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result raised outside completion");

endmodule

>>> sim/touch_panel_calibrate_and_track_tb.sv
`timescale 1ns / 100ps

module touch_panel_calibrate_and_track_tb;
  import tpct_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned RANDOM_ITEMS = 1750;
  localparam int unsigned PHASES       = 7;

  // One expected touch event
  typedef struct {
    logic        touching;
    logic [7:0]  x_rd;
    logic [7:0]  y_rd;
    logic [15:0] x_px;
    logic [15:0] y_px;
    logic [31:0] held;
    logic        landscape;
    logic        ok;
  } touch_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [11:0] cfg_data_i = '0;

  touch_panel_calibrate_and_track uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Calibration copy
  logic [11:0] cal_width  = '0;
  logic [11:0] cal_height = '0;
  logic [7:0]  cal_min_x  = 8'd0;
  logic [7:0]  cal_max_x  = 8'd255;
  logic [7:0]  cal_min_y  = 8'd0;
  logic [7:0]  cal_max_y  = 8'd255;
  logic        cal_flip   = 1'b0;

  // Tracking state copy
  logic [7:0]  kept_x_rd      = '0;
  logic [7:0]  kept_y_rd      = '0;
  logic [15:0] kept_x_px      = '0;
  logic [15:0] kept_y_px      = '0;
  logic        pen_pressed    = 1'b0;
  logic [31:0] press_began_ms = '0;
  logic [31:0] kept_held_ms   = '0;

  touch_event_t pending_events[$];

  int unsigned mismatches      = 0;
  int unsigned samples_sent    = 0;
  int unsigned events_checked  = 0;
  int unsigned presses_run     = 0;
  int unsigned full_scale_seen = 0;
  int unsigned settings_used   = 0;
  bit          idle_enable     = 1'b0;
  logic [31:0] t_ms            = '0;

  // (pos - lo) * pixels / (hi - lo), floored and saturated
  function automatic logic [15:0] scale_to_pixels(input logic [7:0] pos, input logic [7:0] lo,
                                                  input logic [7:0] hi,
                                                  input logic [11:0] pixels);
    logic [19:0] prod;
    logic [19:0] quo;
    if (pos < lo || hi <= lo) return 16'd0;
    prod = 20'(pos - lo) * 20'(pixels);
    quo  = prod / 20'(hi - lo);
    return (quo > 20'd65535) ? 16'hFFFF : quo[15:0];
  endfunction

  // Advance the tracking state by one sample and return the event it produces
  function automatic touch_event_t predict_touch(input logic [7:0] raw_x, input logic [7:0] raw_y,
                                                 input logic pen, input logic [31:0] now);
    touch_event_t ev;
    logic [7:0]   xr;
    logic [7:0]   yr;
    logic         wide;
    logic         usable;
    wide   = cal_width >= cal_height;
    usable = (raw_x != FULL_SCALE) && (raw_y != FULL_SCALE);
    if (pen) begin
      if (usable) begin
        // portrait turns the panel a quarter
        xr = wide ? raw_x : raw_y;
        yr = wide ? raw_y : FULL_SCALE - raw_x;
        if (cal_flip) begin
          xr = FULL_SCALE - xr;
          yr = FULL_SCALE - yr;
        end
        kept_x_rd = xr;
        kept_y_rd = yr;
        kept_x_px = scale_to_pixels(xr, cal_min_x, cal_max_x, cal_width);
        kept_y_px = scale_to_pixels(yr, cal_min_y, cal_max_y, cal_height);
      end
      if (!pen_pressed) begin
        pen_pressed    = 1'b1;
        press_began_ms = now;
      end else begin
        kept_held_ms = now - press_began_ms;
      end
    end else begin
      pen_pressed = 1'b0;
    end
    ev.touching  = pen;
    ev.x_rd      = kept_x_rd;
    ev.y_rd      = kept_y_rd;
    ev.x_px      = kept_x_px;
    ev.y_px      = kept_y_px;
    ev.held      = kept_held_ms;
    ev.landscape = wide;
    ev.ok        = usable;
    return ev;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("ERROR at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (!idle_enable) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 11) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Send one sample request; the prediction is taken at the accepting edge
  task automatic send_sample(input logic [7:0] raw_x, input logic [7:0] raw_y,
                             input logic pen, input logic [31:0] now);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = {now, raw_y, raw_x};
    s_axis_tuser  = pen;
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_events.push_back(predict_touch(raw_x, raw_y, pen, now));
    samples_sent++;
    if (raw_x == FULL_SCALE || raw_y == FULL_SCALE) full_scale_seen++;
  endtask

  // Stop sending and wait for every outstanding event
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_events.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [11:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_WIDTH_PIXELS:  cal_width  = value;
      CFG_HEIGHT_PIXELS: cal_height = value;
      CFG_MIN_X:         cal_min_x  = value[7:0];
      CFG_MAX_X:         cal_max_x  = value[7:0];
      CFG_MIN_Y:         cal_min_y  = value[7:0];
      CFG_MAX_Y:         cal_max_y  = value[7:0];
      CFG_FLIP:          cal_flip   = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_calibration(input logic [11:0] w, input logic [11:0] h,
                                   input logic [7:0] min_x, input logic [7:0] max_x,
                                   input logic [7:0] min_y, input logic [7:0] max_y,
                                   input logic flip);
    // junk in the unused upper bits must be dropped
    write_register(CFG_WIDTH_PIXELS, w);
    write_register(CFG_HEIGHT_PIXELS, h);
    write_register(CFG_MIN_X, {4'($urandom), min_x});
    write_register(CFG_MAX_X, {4'($urandom), max_x});
    write_register(CFG_MIN_Y, {4'($urandom), min_y});
    write_register(CFG_MAX_Y, {4'($urandom), max_y});
    write_register(CFG_FLIP, {11'($urandom), flip});
    settings_used++;
  endtask

  // Receiver back-pressure
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Result checker
  always @(posedge clk_i) begin : check_events
    touch_event_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("result with nothing expected, held_ms", m_axis_tdata[79:48], '0);
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tuser[0] !== want.touching)
          report_mismatch("touching", m_axis_tuser[0], want.touching);
        if (m_axis_tdata[7:0] !== want.x_rd)
          report_mismatch("x_reading", m_axis_tdata[7:0], want.x_rd);
        if (m_axis_tdata[15:8] !== want.y_rd)
          report_mismatch("y_reading", m_axis_tdata[15:8], want.y_rd);
        if (m_axis_tdata[31:16] !== want.x_px)
          report_mismatch("x_pixel", m_axis_tdata[31:16], want.x_px);
        if (m_axis_tdata[47:32] !== want.y_px)
          report_mismatch("y_pixel", m_axis_tdata[47:32], want.y_px);
        if (m_axis_tdata[79:48] !== want.held)
          report_mismatch("held_ms", m_axis_tdata[79:48], want.held);
        if (m_axis_tuser[1] !== want.landscape)
          report_mismatch("landscape", m_axis_tuser[1], want.landscape);
        if (m_axis_tuser[2] !== want.ok)
          report_mismatch("reading_ok", m_axis_tuser[2], want.ok);
      end
      events_checked++;
    end
  end

  // Watchdog: too long without any request moving ends the run
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no request moved for %0d cycles", STALL_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Reset values: zero pixels, full reading range, landscape
  task automatic test_reset_defaults();
    send_sample(8'd0, 8'd0, 1'b1, 32'd0);
    send_sample(8'd254, 8'd254, 1'b1, 32'hFFFF_FFFF);
    send_sample(FULL_SCALE, 8'd10, 1'b1, 32'd5);
    send_sample(8'd10, FULL_SCALE, 1'b0, 32'd6);
    drain_results();
  endtask

  // Landscape, saturation on a one-count range, reading below min, held wrap
  task automatic test_landscape_saturation();
    write_calibration(12'd4095, 12'd100, 8'd10, 8'd11, 8'd0, 8'd255, 1'b0);
    send_sample(8'd11, 8'd50, 1'b1, 32'd100);
    send_sample(8'd5, 8'd50, 1'b1, 32'd300);
    send_sample(8'd254, 8'd254, 1'b1, 32'd50);
    send_sample(FULL_SCALE, FULL_SCALE, 1'b1, 32'd60);
    send_sample(8'd1, 8'd2, 1'b0, 32'd70);
    drain_results();
  endtask

  // Portrait with flip, empty x range, one-count y range
  task automatic test_portrait_flip_empty_range();
    write_calibration(12'd100, 12'd4095, 8'd200, 8'd100, 8'd0, 8'd1, 1'b1);
    send_sample(8'd3, 8'd7, 1'b1, 32'h8000_0000);
    send_sample(8'd200, 8'd0, 1'b1, 32'h8000_0010);
    send_sample(8'd0, 8'd254, 1'b1, 32'h7FFF_FFFF);
    send_sample(8'd9, 8'd9, 1'b0, 32'h8000_0020);
    send_sample(8'd254, 8'd0, 1'b1, 32'h8000_0030);
    drain_results();
  endtask

  // Equal sizes count as landscape; min equal to max gives an empty range
  task automatic test_equal_sizes();
    write_calibration(12'd4095, 12'd4095, 8'd0, 8'd255, 8'd255, 8'd255, 1'b0);
    send_sample(8'd0, 8'd0, 1'b1, 32'd1000);
    send_sample(8'd254, 8'd1, 1'b1, 32'd1001);
    send_sample(8'd128, 8'd127, 1'b0, 32'd1002);
    drain_results();
    write_calibration(12'd0, 12'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
    send_sample(8'd77, 8'd33, 1'b1, 32'd2000);
    drain_results();
  endtask

  function automatic logic [7:0] pick_reading();
    int unsigned roll;
    roll = $urandom_range(0, 24);
    if (roll == 0) return FULL_SCALE;
    if (roll == 1) return 8'd0;
    if (roll == 2) return 8'd254;
    return 8'($urandom_range(0, 254));
  endfunction

  function automatic logic [11:0] pick_pixels();
    case ($urandom_range(0, 4))
      0:       return 12'd0;
      1:       return 12'd4095;
      2:       return 12'($urandom_range(1, 16));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic pick_range(output logic [7:0] lo, output logic [7:0] hi);
    case ($urandom_range(0, 5))
      0: begin
        lo = 8'($urandom);
        hi = 8'($urandom);
      end
      1: begin
        lo = 8'($urandom_range(0, 254));
        hi = lo + 8'd1;
      end
      2: begin
        lo = 8'd0;
        hi = 8'd255;
      end
      default: begin
        lo = 8'($urandom_range(0, 100));
        hi = 8'($urandom_range(150, 255));
      end
    endcase
  endtask

  // One press: one to twenty down samples, then one or two up samples
  task automatic run_press();
    int unsigned downs;
    if ($urandom_range(0, 9) == 0) t_ms = $urandom();
    else if ($urandom_range(0, 9) == 0) t_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
    downs = $urandom_range(1, 20);
    repeat (downs) begin
      send_sample(pick_reading(), pick_reading(), 1'b1, t_ms);
      t_ms += $urandom_range(1, 250);
    end
    repeat ($urandom_range(1, 2)) begin
      send_sample(pick_reading(), pick_reading(), 1'b0, t_ms);
      t_ms += $urandom_range(1, 250);
    end
    presses_run++;
  endtask

  // Random presses across several calibrations, plus noise samples
  task automatic test_random_presses();
    logic [7:0]  lo_x, hi_x, lo_y, hi_y;
    int unsigned phase_end;
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      pick_range(lo_x, hi_x);
      pick_range(lo_y, hi_y);
      write_calibration(pick_pixels(), pick_pixels(), lo_x, hi_x, lo_y, hi_y, 1'($urandom));
      idle_enable = (phase % 3) != 0;
      phase_end = samples_sent + RANDOM_ITEMS / PHASES;
      while (samples_sent < phase_end) begin
        if ($urandom_range(0, 7) == 0)
          send_sample(8'($urandom), 8'($urandom), 1'($urandom), $urandom());
        else
          run_press();
        // now and then hold off until the block has caught up
        if ($urandom_range(0, 15) == 0) drain_results();
      end
      drain_results();
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_defaults();
    idle_enable = 1'b1;
    test_landscape_saturation();
    test_portrait_flip_empty_range();
    test_equal_sizes();
    test_random_presses();

    drain_results();
    repeat (50) @(posedge clk_i);
    $display("Covered %0d samples in %0d presses, %0d with a full scale reading,",
             samples_sent, presses_run, full_scale_seen);
    $display("over %0d calibration settings; %0d events checked, %0d mismatches",
             settings_used, events_checked, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
